@@ rtl/mdtag_pkg.sv @@
package mdtag_pkg;

  localparam int CHAR_W = 8;
  localparam int POS_W  = 31;
  localparam int RUN_W  = 16;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_C     = 8'h43;
  localparam logic [CHAR_W-1:0] CH_G     = 8'h47;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h54;

  typedef struct packed {
    logic [CHAR_W-1:0] md_char;
    logic [POS_W-1:0]  ref_start;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] ref_position;
    logic             has_position;
    logic             end_of_record;
  } result_t;

endpackage

@@ rtl/mdtag_in_if.sv @@
interface mdtag_in_if;
  import mdtag_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] md_char;
  logic [POS_W-1:0]  ref_start;
  logic              last;

  modport source (output valid, output md_char, output ref_start, output last,
                  input ready);
  modport sink   (input valid, input md_char, input ref_start, input last,
                  output ready);
endinterface

@@ rtl/mdtag_out_if.sv @@
interface mdtag_out_if;
  import mdtag_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] ref_position;
  logic             has_position;
  logic             end_of_record;

  modport source (output valid, output ref_position, output has_position,
                  output end_of_record, input ready);
  modport sink   (input valid, input ref_position, input has_position,
                  input end_of_record, output ready);
endinterface

@@ rtl/mdtag_parse.sv @@
module mdtag_parse #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  mdtag_pkg::in_item_t item,
  output mdtag_pkg::result_t  res,
  output logic                emit
);
  import mdtag_pkg::*;

  localparam int MW    = LENGTH_BITS + 4;
  localparam int SUM_W = ((LENGTH_BITS > POS_W) ? LENGTH_BITS : POS_W) + 1;

  logic [LENGTH_BITS-1:0] offset_r, offset_nxt;
  logic [LENGTH_BITS-1:0] acc_r, acc_nxt;
  logic [RUN_W-1:0]       run_len_r, run_len_nxt;
  logic                   caret_r, caret_nxt;
  logic                   base_r, base_nxt;
  logic                   in_digits_r, in_digits_nxt;

  function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] a,
                                                     input logic [LENGTH_BITS-1:0] b);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : s[LENGTH_BITS-1:0];
  endfunction

  logic                   is_digit, is_caret, is_base;
  logic [3:0]             digit;
  logic [MW-1:0]          prod;
  logic [LENGTH_BITS-1:0] acc_sat;
  logic [LENGTH_BITS-1:0] off_pre;
  logic [RUN_W-1:0]       run_inc;
  logic [RUN_W-1:0]       cl_len;
  logic                   cl_caret, cl_base, cl_open, do_close, hit;
  logic [LENGTH_BITS-1:0] cl_off, add_amt;
  logic [SUM_W-1:0]       pos_sum;
  logic [POS_W-1:0]       pos;

  always_comb begin
    is_digit = (item.md_char >= CH_ZERO) && (item.md_char <= CH_NINE);
    is_caret = (item.md_char == CH_CARET);
    is_base  = (item.md_char == CH_A) || (item.md_char == CH_C) ||
               (item.md_char == CH_G) || (item.md_char == CH_T);
    digit    = 4'(item.md_char - CH_ZERO);

    // acc * 10 + digit as two shifts and two adds
    prod    = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + MW'(digit);
    acc_sat = (prod[MW-1:LENGTH_BITS] != 4'b0) ? {LENGTH_BITS{1'b1}}
                                                : prod[LENGTH_BITS-1:0];

    // a non-digit ends any digit run first
    off_pre = in_digits_r ? sat_add(offset_r, acc_r) : offset_r;
    run_inc = (run_len_r == RUN_MAX) ? run_len_r : run_len_r + 1'b1;

    // the run that closes: the open one on a digit, the lengthened one on last
    cl_len   = is_digit ? run_len_r : run_inc;
    cl_caret = is_digit ? caret_r : (caret_r | is_caret);
    cl_base  = is_digit ? base_r  : (base_r | is_base);
    cl_off   = is_digit ? offset_r : off_pre;
    cl_open  = (cl_len != '0);
    do_close = is_digit || item.last;
    hit      = do_close && cl_open && !cl_caret && cl_base;

    pos_sum = SUM_W'(item.ref_start) + SUM_W'(cl_off);
    pos     = (pos_sum > SUM_W'(POS_MAX)) ? POS_MAX : pos_sum[POS_W-1:0];

    // only a closing on a digit carries its offset forward
    if (run_len_r != '0 && caret_r) begin
      add_amt = LENGTH_BITS'(run_len_r - 1'b1);
    end else if (run_len_r != '0 && base_r) begin
      add_amt = LENGTH_BITS'(1);
    end else begin
      add_amt = '0;
    end

    emit              = hit || item.last;
    res.ref_position  = hit ? pos : '0;
    res.has_position  = hit;
    res.end_of_record = item.last;

    if (item.last) begin
      offset_nxt    = '0;
      acc_nxt       = '0;
      run_len_nxt   = '0;
      caret_nxt     = 1'b0;
      base_nxt      = 1'b0;
      in_digits_nxt = 1'b0;
    end else if (is_digit) begin
      offset_nxt    = sat_add(offset_r, add_amt);
      acc_nxt       = acc_sat;
      run_len_nxt   = '0;
      caret_nxt     = 1'b0;
      base_nxt      = 1'b0;
      in_digits_nxt = 1'b1;
    end else begin
      offset_nxt    = off_pre;
      acc_nxt       = '0;
      run_len_nxt   = run_inc;
      caret_nxt     = caret_r | is_caret;
      base_nxt      = base_r | is_base;
      in_digits_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= '0;
      acc_r       <= '0;
      run_len_r   <= '0;
      caret_r     <= 1'b0;
      base_r      <= 1'b0;
      in_digits_r <= 1'b0;
    end else if (step) begin
      offset_r    <= offset_nxt;
      acc_r       <= acc_nxt;
      run_len_r   <= run_len_nxt;
      caret_r     <= caret_nxt;
      base_r      <= base_nxt;
      in_digits_r <= in_digits_nxt;
    end
  end

  a_runs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    in_digits_r |-> (run_len_r == '0 && !caret_r && !base_r))
    else $error("digit run and non-digit run open together");

  a_acc_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !in_digits_r |-> (acc_r == '0))
    else $error("match length held outside a digit run");

  a_record_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.last) |=> (offset_r == '0 && run_len_r == '0 && !in_digits_r))
    else $error("state not cleared after the last character");

endmodule

@@ rtl/md_tag_mismatch_positions.sv @@
// Takes one MD tag character per cycle and returns a result whenever a
// mismatch run closes, and exactly one result (end_of_record set, also with
// any mismatch closing there) on each record's last character. A request is
// held in an input register and its result in an output register before it
// is offered. The offset and run registers update on each step, so the
// sustained rate is one character per cycle while no result stalls;
// in_chan.ready drops only while a finished result waits and the held
// character would produce another one.
module md_tag_mismatch_positions #(
  parameter int LENGTH_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  mdtag_in_if.sink           in_chan,
  mdtag_out_if.source        out_chan
);
  import mdtag_pkg::*;

  logic     in_valid_r;
  in_item_t in_item_r;
  logic     out_valid_r;
  result_t  out_res_r;

  result_t  res;
  logic     emit;
  logic     out_free;
  logic     step;

  assign out_free      = !out_valid_r || out_chan.ready;
  assign step          = in_valid_r && (!emit || out_free);
  assign in_chan.ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_item_r.md_char   <= in_chan.md_char;
      in_item_r.ref_start <= in_chan.ref_start;
      in_item_r.last      <= in_chan.last;
    end
  end

  mdtag_parse #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .res   (res),
    .emit  (emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.ref_position  = out_res_r.ref_position;
  assign out_chan.has_position  = out_res_r.has_position;
  assign out_chan.end_of_record = out_res_r.end_of_record;

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.has_position || out_res_r.end_of_record))
    else $error("result without mismatch or end of record");

  a_no_position_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.has_position) |-> (out_res_r.ref_position == '0))
    else $error("position set on a result without mismatch");

  a_blocked_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !step) |=> (in_valid_r && $stable(in_item_r)))
    else $error("held character lost or changed while blocked");

endmodule
